// File: design/gpmo_pkg.sv
// Shared constants, types and controller/datapath signal groups for the
// masked-output register window. No dependencies.
`default_nettype none

package gpmo_pkg;

  localparam int WindowBytes = 8192;
  localparam int BankCount   = 32;

  localparam int AddrW = 14;
  localparam int DataW = 32;
  localparam int SizeW = 3;

  localparam int OutBase    = 32'h1700;
  localparam int InBase     = 32'h1740;
  localparam int MaskedBase = 32'h1780;

  localparam int Lanes    = 4;
  localparam int LaneSelW = 2;
  localparam int Rows     = WindowBytes / Lanes;
  localparam int RowW     = $clog2(Rows);
  localparam int BankW    = (BankCount > 1) ? $clog2(BankCount) : 1;

  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  localparam logic [SizeW-1:0] SizeWord = SizeW'(4);

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StLoad  = 3'b100
  } state_e;

  typedef struct packed {
    logic clear;
    logic issue;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/gpmo_if.sv
// Request and response channel interfaces of the register window.
// Depends on gpmo_pkg.
`default_nettype none

interface gpmo_req_if;
  import gpmo_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [AddrW-1:0] address;
  logic [SizeW-1:0] access_size;
  logic [DataW-1:0] write_data;

  modport source (output valid, action, address, access_size, write_data, input ready);
  modport sink   (input valid, action, address, access_size, write_data, output ready);
endinterface

interface gpmo_rsp_if;
  import gpmo_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic             access_error;

  modport source (output valid, read_data, access_error, input ready);
  modport sink   (input valid, read_data, access_error, output ready);
endinterface

`default_nettype wire

// File: design/gpmo_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module gpmo_ram #(
  parameter int Depth = 2048,
  parameter int Width = 8,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/gpmo_ctrl.sv
// Controller: clearing pass after reset, request acceptance, result hand-off.
// Depends on gpmo_pkg.
`default_nettype none

module gpmo_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output gpmo_pkg::dp_cmd_t          cmd_o,
  input  wire gpmo_pkg::dp_status_t  status_i
);
  import gpmo_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_ready;

  assign in_ready = (state_q == StIdle) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (status_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i && in_ready) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_comb begin
    if (state_q == StLoad) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.clear  = (state_q == StClear);
  assign cmd_o.issue  = in_valid_i && in_ready;
  assign cmd_o.load   = (state_q == StLoad);
  assign in_ready_o   = in_ready;
  assign out_valid_o  = out_valid_q;

endmodule

`default_nettype wire

// File: design/gpmo_dp.sv
// Datapath: byte-lane store, bank output latches, read assembly and result register.
// Depends on gpmo_pkg and gpmo_ram.
`default_nettype none

module gpmo_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gpmo_pkg::dp_cmd_t           cmd_i,
  output gpmo_pkg::dp_status_t             status_o,
  input  wire logic                        action_i,
  input  wire logic [gpmo_pkg::AddrW-1:0]  address_i,
  input  wire logic [gpmo_pkg::SizeW-1:0]  access_size_i,
  input  wire logic [gpmo_pkg::DataW-1:0]  write_data_i,
  output logic      [gpmo_pkg::DataW-1:0]  read_data_o,
  output logic                             access_error_o
);
  import gpmo_pkg::*;

  localparam logic [AddrW-1:0] OutLo    = AddrW'(OutBase);
  localparam logic [AddrW-1:0] OutHi    = AddrW'(OutBase + 2 * BankCount);
  localparam logic [AddrW-1:0] InLo     = AddrW'(InBase);
  localparam logic [AddrW-1:0] InHi     = AddrW'(InBase + 2 * BankCount);
  localparam logic [AddrW-1:0] MaskedLo = AddrW'(MaskedBase);
  localparam logic [AddrW-1:0] MaskedHi = AddrW'(MaskedBase + 4 * BankCount);
  localparam logic [AddrW:0]   WinEnd   = (AddrW + 1)'(WindowBytes);
  localparam logic [RowW-1:0]  LastRow  = RowW'(Rows - 1);

  logic [RowW-1:0]  clr_cnt_q;
  logic [15:0]      latch_q [BankCount];
  logic [15:0]      latch_d [BankCount];

  logic [AddrW:0]   end_sum;
  logic             err;
  logic             wr_ok;
  logic             masked_hit;
  logic [BankW-1:0] masked_bank;
  logic [AddrW-1:0] mask_off;

  logic [AddrW-1:0] byte_off  [Lanes];
  logic             byte_act  [Lanes];
  logic             byte_out  [Lanes];
  logic             byte_in   [Lanes];
  logic [BankW-1:0] byte_bank [Lanes];
  logic [7:0]       byte_lat  [Lanes];
  logic [7:0]       byte_wd   [Lanes];

  logic [LaneSelW-1:0] lane_idx [Lanes];
  logic [AddrW-1:0]    lane_off [Lanes];
  logic                lane_act [Lanes];
  logic                lane_we  [Lanes];
  logic                lane_re  [Lanes];
  logic [RowW-1:0]     lane_row [Lanes];
  logic [7:0]          lane_wd  [Lanes];
  logic [7:0]          lane_rd  [Lanes];

  logic                is_rd_q;
  logic                err_q;
  logic [LaneSelW-1:0] addr_lo_q;
  logic                act_q     [Lanes];
  logic                lat_hit_q [Lanes];
  logic [7:0]          lat_byte_q[Lanes];

  logic [DataW-1:0]    asm_data;
  logic [DataW-1:0]    read_data_q;
  logic                access_error_q;

  assign end_sum = {1'b0, address_i} + {{(AddrW + 1 - SizeW){1'b0}}, access_size_i};
  assign err     = (access_size_i == '0) || (access_size_i > SizeWord) || (end_sum > WinEnd);
  assign wr_ok   = (action_i == ActWrite) && !err;

  assign mask_off    = address_i - MaskedLo;
  assign masked_bank = mask_off[BankW+1:2];
  assign masked_hit  = wr_ok && (access_size_i == SizeWord) && (address_i >= MaskedLo) &&
                       (address_i < MaskedHi) && (address_i[1:0] == 2'b00);

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      logic [AddrW-1:0] rel;
      byte_off[i]  = address_i + AddrW'(i);
      byte_act[i]  = (SizeW'(i) < access_size_i);
      byte_out[i]  = (byte_off[i] >= OutLo) && (byte_off[i] < OutHi);
      byte_in[i]   = (byte_off[i] >= InLo) && (byte_off[i] < InHi);
      rel          = byte_out[i] ? (byte_off[i] - OutLo) : (byte_off[i] - InLo);
      byte_bank[i] = rel[BankW:1];
      byte_lat[i]  = byte_off[i][0] ? latch_q[byte_bank[i]][15:8] : latch_q[byte_bank[i]][7:0];
      byte_wd[i]   = write_data_i[8*i +: 8];
    end
  end

  always_comb begin
    for (int b = 0; b < BankCount; b++) begin
      latch_d[b] = latch_q[b];
      if (masked_hit && (masked_bank == BankW'(b))) begin
        latch_d[b] = (latch_q[b] & ~write_data_i[31:16]) |
                     (write_data_i[15:0] & write_data_i[31:16]);
      end
      for (int i = 0; i < Lanes; i++) begin
        if (wr_ok && byte_act[i] && byte_out[i] && (byte_bank[i] == BankW'(b))) begin
          if (byte_off[i][0]) begin
            latch_d[b][15:8] = byte_wd[i];
          end else begin
            latch_d[b][7:0] = byte_wd[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BankCount; b++) begin
        latch_q[b] <= '0;
      end
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.issue) begin
        for (int b = 0; b < BankCount; b++) begin
          latch_q[b] <= latch_d[b];
        end
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + RowW'(1);
      end
    end
  end

  assign status_o.clear_last = (clr_cnt_q == LastRow);

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      lane_idx[k] = LaneSelW'(k) - address_i[LaneSelW-1:0];
      lane_off[k] = address_i + AddrW'(lane_idx[k]);
      lane_act[k] = ({1'b0, lane_idx[k]} < access_size_i);
      if (cmd_i.clear) begin
        lane_we[k]  = 1'b1;
        lane_re[k]  = 1'b0;
        lane_row[k] = clr_cnt_q;
        lane_wd[k]  = '0;
      end else begin
        lane_we[k]  = cmd_i.issue && wr_ok && lane_act[k] &&
                      !((lane_off[k] >= OutLo) && (lane_off[k] < OutHi)) &&
                      !((lane_off[k] >= InLo) && (lane_off[k] < InHi));
        lane_re[k]  = cmd_i.issue && (action_i == ActRead);
        lane_row[k] = lane_off[k][RowW+1:2];
        lane_wd[k]  = write_data_i[8*lane_idx[k] +: 8];
      end
    end
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    gpmo_ram #(
      .Depth (Rows),
      .Width (8)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we[k]),
      .re_i    (lane_re[k]),
      .addr_i  (lane_row[k]),
      .wdata_i (lane_wd[k]),
      .rdata_o (lane_rd[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      is_rd_q   <= (action_i == ActRead);
      err_q     <= err;
      addr_lo_q <= address_i[LaneSelW-1:0];
      for (int i = 0; i < Lanes; i++) begin
        act_q[i]      <= byte_act[i];
        lat_hit_q[i]  <= byte_out[i] || byte_in[i];
        lat_byte_q[i] <= byte_lat[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      logic [LaneSelW-1:0] sel;
      sel = addr_lo_q + LaneSelW'(i);
      if (!is_rd_q || err_q || !act_q[i]) begin
        asm_data[8*i +: 8] = '0;
      end else if (lat_hit_q[i]) begin
        asm_data[8*i +: 8] = lat_byte_q[i];
      end else begin
        asm_data[8*i +: 8] = lane_rd[sel];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      read_data_q    <= asm_data;
      access_error_q <= err_q;
    end
  end

  assign read_data_o    = read_data_q;
  assign access_error_o = access_error_q;

endmodule

`default_nettype wire

// File: design/gpio_port_masked_output_regs.sv
// GPIO port masked-output register window: top level.
// Depends on gpmo_pkg, gpmo_if, gpmo_ctrl, gpmo_dp (and gpmo_ram below it).
//
// Usage:
//   req_i carries one bus access per beat: action (read/write), byte address,
//   access size 1..4 and little-endian write data. rsp_o returns one beat per
//   request: read data (zero for writes and rejected accesses) and an error
//   flag for bad sizes or accesses running past the 8 KiB window.
//   Timing: the store and latches update as a request is accepted, and the
//   result register loads in the StLoad state that follows; the response is
//   valid from then on. No new request is taken before that load, which
//   follows the registered read of the four byte-lane RAMs.
//   Reset: latches clear at once; then a clearing pass writes zero to all
//   2048 rows of the byte lanes, one row a cycle, with req_i.ready low until
//   the pass is done.
//   Stall: a response held by rsp_o.ready low keeps its payload; the next
//   request is taken in the same cycle the pending response leaves.
`default_nettype none

module gpio_port_masked_output_regs (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gpmo_req_if.sink   req_i,
  gpmo_rsp_if.source rsp_o
);
  import gpmo_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gpmo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  gpmo_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (req_i.action),
    .address_i      (req_i.address),
    .access_size_i  (req_i.access_size),
    .write_data_i   (req_i.write_data),
    .read_data_o    (rsp_o.read_data),
    .access_error_o (rsp_o.access_error)
  );

endmodule

`default_nettype wire
